### hdl/lru_kv_pkg.sv
// Shared constants, types and state encoding for the LRU key-value cache.
`timescale 1ns / 1ps

package lru_kv_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CAP_W     = 5;
  localparam int WORD_W    = 32;
  localparam int KEEP_W    = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(ENTRIES);
  localparam logic [WORD_W-1:0] MISS_VALUE = '1;
  localparam logic [WORD_W-1:0] SET_VALUE  = '0;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_SET = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } lru_kv_state_t;

  typedef struct packed {
    logic start;
    logic commit;
  } lru_kv_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } lru_kv_sts_t;

endpackage

### hdl/lru_kv_ctrl.sv
// Controller state machine: accept a request, run the scan, commit the update.
`timescale 1ns / 1ps

module lru_kv_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lru_kv_pkg::lru_kv_sts_t sts,
  output lru_kv_pkg::lru_kv_cmd_t cmd
);

  lru_kv_pkg::lru_kv_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lru_kv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      lru_kv_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = lru_kv_pkg::ST_SCAN;
        end
      end
      lru_kv_pkg::ST_SCAN: begin
        if (sts.scan_done) begin
          state_next = lru_kv_pkg::ST_COMMIT;
        end
      end
      lru_kv_pkg::ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = lru_kv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lru_kv_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/lru_kv_datapath.sv
// Datapath: entry stores, recency ranks, scan pipeline and result register.
`timescale 1ns / 1ps

module lru_kv_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lru_kv_pkg::CAP_W-1:0]        cfg_wdata,
  input  logic                                mode,
  input  logic signed [lru_kv_pkg::WORD_W-1:0] key,
  input  logic signed [lru_kv_pkg::WORD_W-1:0] value,
  input  lru_kv_pkg::lru_kv_cmd_t             cmd,
  output lru_kv_pkg::lru_kv_sts_t             sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit,
  output logic signed [lru_kv_pkg::WORD_W-1:0] read_value
);

  localparam int N   = lru_kv_pkg::ENTRIES;
  localparam int IW  = lru_kv_pkg::IDX_W;
  localparam int WW  = lru_kv_pkg::WORD_W;
  localparam int KW  = lru_kv_pkg::KEEP_W;

  logic [lru_kv_pkg::CAP_W-1:0] capacity;

  logic          req_mode;
  logic [WW-1:0] req_key;
  logic [WW-1:0] req_value;

  logic [WW-1:0] key_mem [N];
  logic [WW-1:0] val_mem [N];
  logic [WW-1:0] key_rd;
  logic [WW-1:0] val_rd;

  logic [N-1:0]  valid;
  logic [IW-1:0] rank [N];

  logic          issue_active;
  logic [IW-1:0] scan_idx;
  logic          cmp_vld;
  logic [IW-1:0] cmp_idx;

  logic          found;
  logic [IW-1:0] found_idx;
  logic [WW-1:0] found_val;
  logic [IW-1:0] found_rank;
  logic          slot_ok;
  logic [IW-1:0] slot_idx;

  logic [KW-1:0] eff_cap;
  logic [KW-1:0] keep;
  logic          hit_here;
  logic          free_here;

  logic          key_we;
  logic          val_we;
  logic [IW-1:0] val_waddr;

  // Capacity register, clamped to 1..ENTRIES where it is used.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lru_kv_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_comb begin
    eff_cap = KW'(capacity);
    if (capacity == '0) begin
      eff_cap = KW'(1);
    end else if (KW'(capacity) > KW'(N)) begin
      eff_cap = KW'(N);
    end
    keep = eff_cap - KW'(1);
  end

  // Hold the request while it is worked on.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_mode  <= mode;
      req_key   <= key;
      req_value <= value;
    end
  end

  // Scan address counter and compare-stage tag.
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_active <= 1'b0;
      scan_idx     <= '0;
      cmp_vld      <= 1'b0;
      cmp_idx      <= '0;
    end else begin
      cmp_vld <= issue_active;
      cmp_idx <= scan_idx;
      if (cmd.start) begin
        issue_active <= 1'b1;
        scan_idx     <= '0;
      end else if (issue_active) begin
        if (scan_idx == IW'(N - 1)) begin
          issue_active <= 1'b0;
        end
        scan_idx <= scan_idx + IW'(1);
      end
    end
  end

  assign hit_here  = cmp_vld && valid[cmp_idx] && (key_rd == req_key);
  assign free_here = cmp_vld && (!valid[cmp_idx] || (KW'(rank[cmp_idx]) >= keep));

  // Record the matching entry and the first slot free after eviction.
  always_ff @(posedge clk) begin
    if (rst) begin
      found   <= 1'b0;
      slot_ok <= 1'b0;
    end else if (cmd.start) begin
      found   <= 1'b0;
      slot_ok <= 1'b0;
    end else begin
      if (hit_here && !found) begin
        found <= 1'b1;
      end
      if (free_here && !slot_ok) begin
        slot_ok <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit_here && !found) begin
      found_idx  <= cmp_idx;
      found_val  <= val_rd;
      found_rank <= rank[cmp_idx];
    end
    if (free_here && !slot_ok) begin
      slot_idx <= cmp_idx;
    end
  end

  // Store writes at commit: value update on a set hit, insert on a set miss.
  always_comb begin
    key_we    = cmd.commit && (req_mode == lru_kv_pkg::MODE_SET) && !found;
    val_we    = cmd.commit && (req_mode == lru_kv_pkg::MODE_SET);
    val_waddr = found ? found_idx : slot_idx;
  end

  always_ff @(posedge clk) begin
    if (issue_active) begin
      key_rd <= key_mem[scan_idx];
    end
    if (key_we) begin
      key_mem[slot_idx] <= req_key;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_active) begin
      val_rd <= val_mem[scan_idx];
    end
    if (val_we) begin
      val_mem[val_waddr] <= req_value;
    end
  end

  // Valid bits and recency ranks, updated per entry at commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int i = 0; i < N; i++) begin
        rank[i] <= '0;
      end
    end else if (cmd.commit) begin
      if (found) begin
        for (int i = 0; i < N; i++) begin
          if (IW'(i) == found_idx) begin
            rank[i] <= '0;
          end else if (valid[i] && (rank[i] < found_rank)) begin
            rank[i] <= rank[i] + IW'(1);
          end
        end
      end else if (req_mode == lru_kv_pkg::MODE_SET) begin
        for (int i = 0; i < N; i++) begin
          if (IW'(i) == slot_idx) begin
            valid[i] <= 1'b1;
            rank[i]  <= '0;
          end else if (valid[i] && (KW'(rank[i]) >= keep)) begin
            valid[i] <= 1'b0;
            rank[i]  <= '0;
          end else if (valid[i]) begin
            rank[i] <= rank[i] + IW'(1);
          end
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit <= found;
      if (req_mode == lru_kv_pkg::MODE_SET) begin
        read_value <= lru_kv_pkg::SET_VALUE;
      end else if (found) begin
        read_value <= found_val;
      end else begin
        read_value <= lru_kv_pkg::MISS_VALUE;
      end
    end
  end

  assign sts.scan_done = cmp_vld && (cmp_idx == IW'(N - 1));
  assign sts.out_free  = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_commit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit while result register is occupied");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit did not produce a result");

  a_set_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && (req_mode == lru_kv_pkg::MODE_SET)) |=> (read_value == '0))
    else $error("set request returned a nonzero value");

  a_insert_has_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && (req_mode == lru_kv_pkg::MODE_SET) && !found) |-> slot_ok)
    else $error("insert without a free slot");
`endif

endmodule

### hdl/lru_key_value_cache_unit.sv
// Top level of the fully associative LRU key-value cache.
`timescale 1ns / 1ps
//
// Usage:
//   Request channel (in_valid/in_ready): mode (0 get, 1 set), key, value.
//   Result channel (out_valid/out_ready): hit and read_value. A get returns
//   the stored value on a hit and all ones on a miss; a set returns zero,
//   with hit telling whether the key was already present.
//   Configuration: cfg_we/cfg_wdata write the capacity register (1..16
//   entries kept before eviction; zero acts as one, larger values as 16).
//   Write it only while no request is in flight.
// Timing:
//   One request at a time. A request is accepted, its scan then reads the
//   16 entries through the registered key/value store read port (one
//   entry per cycle, plus one compare stage), and it is then committed;
//   a new request is taken only after that commit.
// Reset (rst, synchronous): all entries invalid, ranks cleared, capacity 16.
// Stall: a finished result waits in the output register; the next request is
//   still accepted and scanned, and its commit holds until the result is taken.

module lru_key_value_cache_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [lru_kv_pkg::CAP_W-1:0]         cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 mode,
  input  logic signed [lru_kv_pkg::WORD_W-1:0] key,
  input  logic signed [lru_kv_pkg::WORD_W-1:0] value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 hit,
  output logic signed [lru_kv_pkg::WORD_W-1:0] read_value
);

  lru_kv_pkg::lru_kv_cmd_t cmd;
  lru_kv_pkg::lru_kv_sts_t sts;

  // Sequence each request: accept, scan, commit.
  lru_kv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Stores, ranks, match search and the result register.
  lru_kv_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mode       (mode),
    .key        (key),
    .value      (value),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .read_value (read_value)
  );

endmodule
